>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: assertion failed");
// Check on every rising clock edge, reset included.
`define ASSERT_ALW(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif
`endif

>>> sv/cfit_pkg.sv
`timescale 1ns / 1ps
package cfit_pkg;

    // Field and datapath widths
    localparam int COORD_W    = 16;
    localparam int RAD_W      = 16;
    localparam int SUM_W      = 48;
    localparam int DIFF_W     = 17;
    localparam int MOP_W      = 18;
    localparam int MUL_W      = 36;
    localparam int PROD_W     = 34;
    localparam int ROOT_W     = 35;
    localparam int TRIAL_W    = 36;
    localparam int ROOT_OUT_W = 17;
    localparam int STEP_W     = 4;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 4;
    localparam int REG_IDX_W  = 2;

    // Ring limits
    localparam int MAX_HITS_DEF = 64;
    localparam int MIN_HITS     = 4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 2'd2;

    typedef logic [STEP_W-1:0] t_step;

    // Program addresses
    localparam t_step ST_WAIT = 4'd0;
    localparam t_step ST_MULX = 4'd1;
    localparam t_step ST_MULY = 4'd2;
    localparam t_step ST_SUM  = 4'd3;
    localparam t_step ST_ROOT = 4'd4;
    localparam t_step ST_RES  = 4'd5;
    localparam t_step ST_SQR  = 4'd6;
    localparam t_step ST_ACC  = 4'd7;
    localparam t_step ST_FIN  = 4'd8;
    localparam t_step ST_EMIT = 4'd9;
    localparam t_step ST_BACK = 4'd10;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_SUM,
        OP_ROOT,
        OP_RES,
        OP_SQR,
        OP_ACC,
        OP_EMIT
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_NOIN,
        C_FULL,
        C_LOOP,
        C_NOTLAST,
        C_OBUSY,
        C_ALWAYS
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uop;

    // Control store: one word per step
    function automatic t_uop ucode(input t_step pc);
        t_uop w;
        unique case (pc)
            ST_WAIT: w = '{op: OP_LOAD, cond: C_NOIN,    target: ST_WAIT};
            ST_MULX: w = '{op: OP_SQX,  cond: C_FULL,    target: ST_FIN};
            ST_MULY: w = '{op: OP_SQY,  cond: C_NONE,    target: ST_WAIT};
            ST_SUM:  w = '{op: OP_SUM,  cond: C_NONE,    target: ST_WAIT};
            ST_ROOT: w = '{op: OP_ROOT, cond: C_LOOP,    target: ST_ROOT};
            ST_RES:  w = '{op: OP_RES,  cond: C_NONE,    target: ST_WAIT};
            ST_SQR:  w = '{op: OP_SQR,  cond: C_NONE,    target: ST_WAIT};
            ST_ACC:  w = '{op: OP_ACC,  cond: C_NOTLAST, target: ST_WAIT};
            ST_FIN:  w = '{op: OP_NOP,  cond: C_NOTLAST, target: ST_WAIT};
            ST_EMIT: w = '{op: OP_EMIT, cond: C_OBUSY,   target: ST_EMIT};
            ST_BACK: w = '{op: OP_NOP,  cond: C_ALWAYS,  target: ST_WAIT};
            default: w = '{op: OP_NOP,  cond: C_ALWAYS,  target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> sv/cfit_hit_if.sv
`timescale 1ns / 1ps
interface cfit_hit_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [cfit_pkg::COORD_W-1:0]     hit_x;
    logic signed [cfit_pkg::COORD_W-1:0]     hit_y;
    logic                                    last_hit;

    modport source (output valid, output hit_x, output hit_y, output last_hit, input ready);
    modport sink   (input valid, input hit_x, input hit_y, input last_hit, output ready);
endinterface

>>> sv/cfit_res_if.sv
`timescale 1ns / 1ps
interface cfit_res_if;
    logic                          valid;
    logic                          ready;
    logic [cfit_pkg::SUM_W-1:0]    chi2_sum;
    logic                          too_few_hits;

    modport source (output valid, output chi2_sum, output too_few_hits, input ready);
    modport sink   (input valid, input chi2_sum, input too_few_hits, output ready);
endinterface

>>> sv/circle_fit_chi2_accumulator.sv
`timescale 1ns / 1ps
// Channel  | Dir | Payload                         | Handshake
// ---------+-----+---------------------------------+-------------------------
// i_hit    | in  | hit_x, hit_y, last_hit          | valid/ready
// o_res    | out | chi2_sum, too_few_hits          | valid/ready, one register
// apb      | in  | center_x, center_y, radius      | psel/penable, pready = 1
//
// Each hit runs the step program: load, square dx and dy, sum, an 18-step
// square root loop, residual, its square and accumulate; no new hit is
// taken until the program is back at the wait step. A hit past MAX_HITS
// skips the sum and count; the emit step runs when a hit closes the ring.
// Synchronous active-low reset clears the config registers, the sum, the
// hit count, the step counter and the result valid.
// A waiting result does not block the next hit; only the emit step of the
// next ring's final hit waits for the result register to drain.
`include "assert_macros.svh"

module circle_fit_chi2_accumulator #(
    parameter int MAX_HITS = cfit_pkg::MAX_HITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cfit_hit_if.sink                      i_hit,
    cfit_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfit_pkg::APB_AW-1:0]   paddr,
    input  logic [cfit_pkg::APB_DW-1:0]   pwdata,
    output logic [cfit_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CntW = $clog2(MAX_HITS + 1);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_HITS);
    localparam logic [CntW-1:0] MinCnt = CntW'(cfit_pkg::MIN_HITS);

    // Config registers
    logic signed [cfit_pkg::COORD_W-1:0] r_cx;
    logic signed [cfit_pkg::COORD_W-1:0] r_cy;
    logic [cfit_pkg::RAD_W-1:0]          r_rad;

    // Sequencer
    cfit_pkg::t_step r_pc;
    cfit_pkg::t_step n_pc;
    cfit_pkg::t_uop  w_uop;
    logic            w_jump;
    logic            w_busy;
    logic            w_accept;

    // Datapath
    logic signed [cfit_pkg::DIFF_W-1:0]  r_dx;
    logic signed [cfit_pkg::DIFF_W-1:0]  r_dy;
    logic                                r_last;
    logic [cfit_pkg::PROD_W-1:0]         r_prod;
    logic [cfit_pkg::PROD_W-1:0]         r_rem;
    logic [cfit_pkg::ROOT_W-1:0]         r_root;
    logic [cfit_pkg::ROOT_W-1:0]         r_bit;
    logic signed [cfit_pkg::MOP_W-1:0]   r_res;
    logic [cfit_pkg::SUM_W-1:0]          r_sum;
    logic [CntW-1:0]                     r_count;

    logic signed [cfit_pkg::MOP_W-1:0]   w_mop;
    logic signed [cfit_pkg::MUL_W-1:0]   w_mul;
    logic [cfit_pkg::TRIAL_W-1:0]        w_trial;
    logic                                w_take;
    logic [cfit_pkg::SUM_W:0]            w_acc;
    logic                                w_full;
    logic                                w_few;

    // Result register
    logic                                r_out_valid;
    logic [cfit_pkg::SUM_W-1:0]          r_out_chi2;
    logic                                r_out_few;

    // APB write side
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_rad <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[cfit_pkg::APB_AW-1:2])
                cfit_pkg::REG_CENTER_X: r_cx  <= pwdata[cfit_pkg::COORD_W-1:0];
                cfit_pkg::REG_CENTER_Y: r_cy  <= pwdata[cfit_pkg::COORD_W-1:0];
                cfit_pkg::REG_RADIUS:   r_rad <= pwdata[cfit_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // APB read side
    always_comb begin
        unique case (paddr[cfit_pkg::APB_AW-1:2])
            cfit_pkg::REG_CENTER_X: prdata = cfit_pkg::APB_DW'(unsigned'(r_cx));
            cfit_pkg::REG_CENTER_Y: prdata = cfit_pkg::APB_DW'(unsigned'(r_cy));
            cfit_pkg::REG_RADIUS:   prdata = cfit_pkg::APB_DW'(r_rad);
            default:                prdata = '0;
        endcase
    end

    // Decode the current control word
    assign w_uop    = cfit_pkg::ucode(r_pc);
    assign w_busy   = r_out_valid && !o_res.ready;
    assign w_full   = (r_count >= MaxCnt);
    assign w_few    = (r_count < MinCnt);
    assign i_hit.ready = (w_uop.op == cfit_pkg::OP_LOAD);
    assign w_accept = i_hit.valid && i_hit.ready;

    // Evaluate the jump condition
    always_comb begin
        unique case (w_uop.cond)
            cfit_pkg::C_NONE:    w_jump = 1'b0;
            cfit_pkg::C_NOIN:    w_jump = !i_hit.valid;
            cfit_pkg::C_FULL:    w_jump = w_full;
            cfit_pkg::C_LOOP:    w_jump = !r_bit[0];
            cfit_pkg::C_NOTLAST: w_jump = !r_last;
            cfit_pkg::C_OBUSY:   w_jump = w_busy;
            cfit_pkg::C_ALWAYS:  w_jump = 1'b1;
            default:             w_jump = 1'b1;
        endcase
    end

    // Advance or jump the step counter
    always_comb begin
        n_pc = w_jump ? w_uop.target : r_pc + cfit_pkg::t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cfit_pkg::ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Shared squarer operand
    always_comb begin
        case (w_uop.op)
            cfit_pkg::OP_SQX: w_mop = cfit_pkg::MOP_W'(r_dx);
            cfit_pkg::OP_SQY: w_mop = cfit_pkg::MOP_W'(r_dy);
            default:          w_mop = r_res;
        endcase
    end

    assign w_mul = w_mop * w_mop;

    // One square root step: trial subtract of root + bit
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign w_take  = ({2'b00, r_rem} >= w_trial);

    // Saturating accumulate
    assign w_acc = {1'b0, r_sum} + cfit_pkg::SUM_W'(r_prod) + (cfit_pkg::SUM_W + 1)'(0);

    // Payload registers of the datapath
    always_ff @(posedge i_clk) begin
        case (w_uop.op)
            cfit_pkg::OP_LOAD: begin
                if (w_accept) begin
                    r_dx   <= {r_cx[cfit_pkg::COORD_W-1], r_cx}
                            - {i_hit.hit_x[cfit_pkg::COORD_W-1], i_hit.hit_x};
                    r_dy   <= {r_cy[cfit_pkg::COORD_W-1], r_cy}
                            - {i_hit.hit_y[cfit_pkg::COORD_W-1], i_hit.hit_y};
                    r_last <= i_hit.last_hit;
                end
            end
            cfit_pkg::OP_SQX: begin
                r_prod <= w_mul[cfit_pkg::PROD_W-1:0];
            end
            cfit_pkg::OP_SQY: begin
                r_rem  <= r_prod;
                r_prod <= w_mul[cfit_pkg::PROD_W-1:0];
            end
            cfit_pkg::OP_SUM: begin
                r_rem  <= r_rem + r_prod;
                r_root <= '0;
                r_bit  <= {1'b1, {(cfit_pkg::ROOT_W-1){1'b0}}};
            end
            cfit_pkg::OP_ROOT: begin
                if (w_take) begin
                    r_rem  <= r_rem - w_trial[cfit_pkg::PROD_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            cfit_pkg::OP_RES: begin
                r_res <= {1'b0, r_root[cfit_pkg::ROOT_OUT_W-1:0]}
                       - {2'b00, r_rad};
            end
            cfit_pkg::OP_SQR: begin
                r_prod <= w_mul[cfit_pkg::PROD_W-1:0];
            end
            default: ;
        endcase
    end

    // Ring state: sum and hit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (w_uop.op == cfit_pkg::OP_ACC) begin
            r_sum   <= w_acc[cfit_pkg::SUM_W] ? '1 : w_acc[cfit_pkg::SUM_W-1:0];
            r_count <= r_count + CntW'(1);
        end else if (w_uop.op == cfit_pkg::OP_EMIT && !w_busy) begin
            r_sum   <= '0;
            r_count <= '0;
        end
    end

    // Result register: load on emit, drop on request taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uop.op == cfit_pkg::OP_EMIT && !w_busy) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uop.op == cfit_pkg::OP_EMIT && !w_busy) begin
            r_out_chi2 <= w_few ? '0 : r_sum;
            r_out_few  <= w_few;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.chi2_sum     = r_out_chi2;
    assign o_res.too_few_hits = r_out_few;

    // Checks
    `ASSERT_RST(a_load_next, i_clk, i_rst_n, w_accept |=> (r_pc == cfit_pkg::ST_MULX))
    `ASSERT_RST(a_root_bit, i_clk, i_rst_n, (r_pc == cfit_pkg::ST_ROOT) |-> $onehot(r_bit))
    `ASSERT_RST(a_count_max, i_clk, i_rst_n, r_count <= MaxCnt)
    `ASSERT_RST(a_emit_clear, i_clk, i_rst_n, (r_pc == cfit_pkg::ST_EMIT && !w_busy) |=> (r_sum == '0 && r_count == '0))
    `ASSERT_RST(a_few_zero, i_clk, i_rst_n, (r_out_valid && r_out_few) |-> (r_out_chi2 == '0))

endmodule
